/* hw/rtl/nsf_pkg.sv */
// nsf_pkg: shared types and constants for the NMEA sentence framer.
// Used by nsf_front, nsf_cmd_fifo, nsf_back and nmea_sentence_framer.
package nsf_pkg;

    localparam int NUM_TYPES_DEF    = 4;
    localparam int HEADER_LEN_DEF   = 6;
    localparam int MAX_SENTENCE_DEF = 128;

    localparam int NUM_PATTERNS = 4;   // pattern registers that exist
    localparam int HDR_MAX_W    = 48;  // widest header, first byte at the top
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int STEP_W       = 3;   // up to six results per command
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_A = 3'd0,
        REG_PATTERN_B = 3'd1,
        REG_PATTERN_C = 3'd2,
        REG_PATTERN_D = 3'd3,
        REG_TYPE_IDS  = 3'd4,
        REG_TYPE_CNT  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_BYTE   = 2'd1,
        ST_TERM   = 2'd2,
        ST_TRUNC  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_REJECT = 3'd0,
        CMD_HEADER = 3'd1,
        CMD_BYTE   = 3'd2,
        CMD_TRUNC  = 3'd3,
        CMD_TERM   = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [7:0]             id;
        logic [7:0]             data;
        logic [7:0]             len;
        logic [HDR_MAX_W-1:0]   hdr;
    } cmd_t;

    typedef struct packed {
        logic [NUM_PATTERNS-1:0][HDR_MAX_W-1:0] pattern;
        logic [31:0]                            ids;
        logic [2:0]                             count;
    } cfg_t;

endpackage

/* hw/rtl/nsf_front.sv */
// nsf_front: takes received bytes, tracks hunt/header/payload phase and turns
// each completed header and payload byte into a back-end command. Depends on nsf_pkg.
module nsf_front
    import nsf_pkg::*;
#(
    parameter int NUM_TYPES    = NUM_TYPES_DEF,
    parameter int HEADER_LEN   = HEADER_LEN_DEF,
    parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output logic       push,
    output cmd_t       cmd
);

    localparam int FILL_W = $clog2(HEADER_LEN + 1);
    localparam int LIM    = (NUM_TYPES < NUM_PATTERNS) ? NUM_TYPES : NUM_PATTERNS;

    phase_t             phase_reg, phase_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         count_reg, count_next;
    logic [7:0]         hdr_reg  [HEADER_LEN];
    logic [7:0]         hdr_cand [HEADER_LEN];
    logic               hdr_wr;

    logic               is_dollar;
    logic               is_nmea;
    logic [FILL_W-1:0]  wr_pos;
    logic [NUM_PATTERNS-1:0] eq;
    logic [3:0]         n_eff;
    logic               hit;
    logic [7:0]         hit_id;
    logic [7:0]         cnt1;
    logic [8:0]         cnt1_plus2;

    assign is_dollar = (in_byte == CH_DOLLAR);
    assign is_nmea   = (in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_Z)
                    || (in_byte >= CH_ZERO && in_byte <= CH_NINE)
                    || is_dollar || in_byte == CH_MINUS || in_byte == CH_COMMA
                    || in_byte == CH_DOT || in_byte == CH_STAR;

    // header as it would look after this byte is stored
    assign wr_pos = is_dollar ? '0 : fill_reg;
    always_comb
    begin
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            hdr_cand[i] = (wr_pos == FILL_W'(i)) ? in_byte : hdr_reg[i];
        end
    end

    assign n_eff = ({1'b0, cfg.count} > 4'(LIM)) ? 4'(LIM) : {1'b0, cfg.count};

    always_comb
    begin
        hit    = 1'b0;
        hit_id = '0;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            eq[k] = 1'b1;
            for (int i = 0; i < HEADER_LEN; i++)
            begin
                if (hdr_cand[i] != cfg.pattern[k][HDR_MAX_W-1-8*i -: 8])
                    eq[k] = 1'b0;
            end
        end
        // lowest enabled pattern wins
        for (int k = NUM_PATTERNS - 1; k >= 0; k--)
        begin
            if (eq[k] && (4'(k) < n_eff))
            begin
                hit    = 1'b1;
                hit_id = cfg.ids[8*k +: 8];
            end
        end
    end

    assign cnt1       = count_reg + 8'd1;
    assign cnt1_plus2 = {1'b0, cnt1} + 9'd2;

    always_comb
    begin
        logic hdr_done;
        hdr_done   = 1'b0;
        hdr_wr     = 1'b0;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        id_next    = id_reg;
        count_next = count_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.kind   = CMD_REJECT;

        for (int i = 0; i < HEADER_LEN; i++)
        begin
            cmd.hdr[HDR_MAX_W-1-8*i -: 8] = hdr_cand[i];
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (is_dollar)
                    begin
                        hdr_wr     = 1'b1;
                        fill_next  = FILL_W'(1);
                        phase_next = PH_HEADER;
                        hdr_done   = (HEADER_LEN == 1);
                    end
                end
                PH_HEADER:
                begin
                    hdr_wr = 1'b1;
                    if (is_dollar)
                    begin
                        fill_next = FILL_W'(1);
                        hdr_done  = (HEADER_LEN == 1);
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                        hdr_done  = (fill_reg == FILL_W'(HEADER_LEN - 1));
                    end
                end
                PH_PAYLOAD:
                begin
                    push     = 1'b1;
                    cmd.id   = id_reg;
                    cmd.data = in_byte;
                    if (is_nmea)
                    begin
                        count_next = cnt1;
                        if (cnt1_plus2 >= 9'(MAX_SENTENCE))
                        begin
                            cmd.kind   = CMD_TRUNC;
                            cmd.len    = cnt1_plus2[7:0];
                            phase_next = PH_HUNT;
                            fill_next  = '0;
                        end
                        else
                        begin
                            cmd.kind = CMD_BYTE;
                        end
                    end
                    else
                    begin
                        cmd.kind   = CMD_TERM;
                        cmd.len    = count_reg + 8'd2;
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase

            if (hdr_done)
            begin
                push = 1'b1;
                if (hit)
                begin
                    cmd.kind   = CMD_HEADER;
                    cmd.id     = hit_id;
                    id_next    = hit_id;
                    count_next = 8'(HEADER_LEN);
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    cmd.kind   = CMD_REJECT;
                    phase_next = PH_HUNT;
                    fill_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
            id_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            id_reg    <= id_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            for (int i = 0; i < HEADER_LEN; i++)
            begin
                hdr_reg[i] <= hdr_cand[i];
            end
        end
    end

    // header fill only ever counts up to the header length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HEADER_LEN))
        else $error("header fill past header length");

    // a payload phase is only entered together with a header command
    a_payload_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PAYLOAD && phase_next == PH_PAYLOAD)
            |-> (push && cmd.kind == CMD_HEADER))
        else $error("payload phase without header command");

    // the sentence count never reaches the bound while in payload
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> ({1'b0, count_reg} + 9'd2 < 9'(MAX_SENTENCE)))
        else $error("sentence count past bound");

endmodule

/* hw/rtl/nsf_cmd_fifo.sv */
// nsf_cmd_fifo: short command queue between front and back end.
// Depends on nsf_pkg for cmd_t and the queue depth.
module nsf_cmd_fifo
    import nsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command queue underflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FIFO_CNT_W'(FIFO_DEPTH))
            |-> (FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0]))
        else $error("queue pointers and count disagree");

endmodule

/* hw/rtl/nsf_back.sv */
// nsf_back: expands queued commands into result beats and holds the
// output register. Depends on nsf_pkg.
module nsf_back
    import nsf_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] type_id,
    output logic [7:0] out_byte,
    output logic [7:0] sentence_length,
    output logic       last
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        id_reg, byte_reg, len_reg;
    logic              last_reg;

    logic              load;
    logic              final_step;
    status_t           r_status;
    logic [7:0]        r_id, r_byte, r_len;
    logic              r_last;
    logic [7:0]        hdr_byte;

    assign load = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        hdr_byte = '0;
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            if (step_reg == STEP_W'(i))
                hdr_byte = head.hdr[HDR_MAX_W-1-8*i -: 8];
        end
    end

    always_comb
    begin
        r_status   = ST_BYTE;
        r_id       = head.id;
        r_byte     = head.data;
        r_len      = '0;
        r_last     = 1'b0;
        final_step = 1'b1;
        unique case (head.kind)
            CMD_REJECT:
            begin
                r_status = ST_REJECT;
                r_id     = '0;
                r_byte   = '0;
                r_last   = 1'b1;
            end
            CMD_HEADER:
            begin
                r_byte     = hdr_byte;
                final_step = (step_reg == STEP_W'(HEADER_LEN - 1));
            end
            CMD_BYTE:
            begin
                r_status = ST_BYTE;
            end
            CMD_TRUNC:
            begin
                final_step = (step_reg == STEP_W'(2));
                if (step_reg != '0)
                begin
                    r_status = ST_TRUNC;
                    r_byte   = (step_reg == STEP_W'(1)) ? CH_CR : CH_LF;
                end
                if (final_step)
                begin
                    r_len  = head.len;
                    r_last = 1'b1;
                end
            end
            CMD_TERM:
            begin
                final_step = (step_reg == STEP_W'(1));
                r_status   = ST_TERM;
                r_byte     = final_step ? CH_LF : CH_CR;
                if (final_step)
                begin
                    r_len  = head.len;
                    r_last = 1'b1;
                end
            end
            default:
            begin
                r_status = ST_REJECT;
                r_last   = 1'b1;
            end
        endcase
    end

    assign pop = load && final_step;

    always_comb
    begin
        step_next = step_reg;
        if (load)
            step_next = final_step ? '0 : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= r_status;
            id_reg     <= r_id;
            byte_reg   <= r_byte;
            len_reg    <= r_len;
            last_reg   <= r_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign type_id         = id_reg;
    assign out_byte        = byte_reg;
    assign sentence_length = len_reg;
    assign last            = last_reg;

    // the step counter stays inside the longest expansion
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg < STEP_W'(HEADER_LEN)) || (step_reg < STEP_W'(3)))
        else $error("expansion step out of range");

    // a command mid-expansion is never left with the queue empty
    a_step_head: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> !empty)
        else $error("expansion step without command");

    // a length only ever travels on the closing beat
    a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && r_len != '0) |-> r_last)
        else $error("length on a non-final beat");

endmodule

/* hw/rtl/nmea_sentence_framer.sv */
// nmea_sentence_framer: top level; configuration registers, front end,
// command queue and back end. Depends on nsf_pkg, nsf_front, nsf_cmd_fifo, nsf_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  input    | in_valid / in_stall    | in_byte
//  result   | out_valid / out_stall  | status, type_id, out_byte, sentence_length, last
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input beat per cycle while the four-entry command queue has room.
// A header match expands to HEADER_LEN result beats, a terminator to two,
// a truncation to three; the back end emits one result beat per cycle while not stalled.
// Results pass through the command queue and the back-end output register.
// Reset clears all configuration to zero and starts hunting for '$'.
// Input stall is the queue-full flag; output stall only backs up the queue.
module nmea_sentence_framer
    import nsf_pkg::*;
#(
    parameter int NUM_TYPES    = NUM_TYPES_DEF,
    parameter int HEADER_LEN   = HEADER_LEN_DEF,
    parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [7:0]            type_id,
    output logic [7:0]            out_byte,
    output logic [7:0]            sentence_length,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic accept;
    logic push, pop, empty, full;
    cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_A: cfg_reg.pattern[0] <= cfg_data;
                REG_PATTERN_B: cfg_reg.pattern[1] <= cfg_data;
                REG_PATTERN_C: cfg_reg.pattern[2] <= cfg_data;
                REG_PATTERN_D: cfg_reg.pattern[3] <= cfg_data;
                REG_TYPE_IDS:  cfg_reg.ids        <= cfg_data[31:0];
                REG_TYPE_CNT:  cfg_reg.count      <= cfg_data[2:0];
                default:       cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    nsf_front #(
        .NUM_TYPES    (NUM_TYPES),
        .HEADER_LEN   (HEADER_LEN),
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .cfg     (cfg_reg),
        .push    (push),
        .cmd     (push_cmd)
    );

    nsf_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    nsf_back #(
        .HEADER_LEN (HEADER_LEN)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .type_id         (type_id),
        .out_byte        (out_byte),
        .sentence_length (sentence_length),
        .last            (last)
    );

endmodule

/* verif/tb.sv */
// tb: self-checking bench for nmea_sentence_framer, byte stream in, framed results out.
// Carries its own sentence-framing predictor; needs nsf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb;
    import nsf_pkg::*;

    localparam int HL           = HEADER_LEN_DEF;
    localparam int MS           = MAX_SENTENCE_DEF;
    localparam int RAND_ITEMS   = 436;
    localparam int RAND_PHASES  = 8;
    localparam int SETTLE       = 10;
    localparam int HOLD_AT      = 60;
    localparam int LONG_HOLD    = 90;
    localparam int MAX_REPORTS  = 10;

    // indexes beyond the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [63:0] HDR_ALPHABET = "GPNRMCAS";

    typedef struct packed {
        status_t    st;
        logic [7:0] id;
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
    } frame_res_t;

    typedef enum logic [1:0] {
        CHK_MODEL  = 2'd0,
        CHK_NONE   = 2'd1,
        CHK_REJECT = 2'd2
    } row_chk_t;

    typedef struct packed {
        logic [7:0] b;
        row_chk_t   chk;
    } dir_row_t;

    localparam frame_res_t REJECT_RES = '{ST_REJECT, 8'h00, 8'h00, 8'h00, 1'b1};

    localparam int DIR_ROWS = 25;
    localparam int PRE_ROWS = 9;
    // first PRE_ROWS run on reset config (nothing enabled), the rest on the first setting
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'hff, CHK_NONE},
        '{CH_DOLLAR, CHK_NONE},
        '{"G", CHK_NONE},
        '{CH_DOLLAR, CHK_NONE},
        '{"G", CHK_NONE},
        '{"P", CHK_NONE},
        '{"G", CHK_NONE},
        '{"G", CHK_NONE},
        '{"A", CHK_REJECT},
        '{CH_DOLLAR, CHK_MODEL},
        '{"G", CHK_MODEL},
        '{"P", CHK_MODEL},
        '{"R", CHK_MODEL},
        '{"M", CHK_MODEL},
        '{"C", CHK_MODEL},
        '{CH_UPPER_A, CHK_MODEL},
        '{CH_UPPER_Z, CHK_MODEL},
        '{CH_ZERO, CHK_MODEL},
        '{CH_NINE, CHK_MODEL},
        '{CH_DOLLAR, CHK_MODEL},
        '{CH_MINUS, CHK_MODEL},
        '{CH_COMMA, CHK_MODEL},
        '{CH_DOT, CHK_MODEL},
        '{CH_STAR, CHK_MODEL},
        '{8'h00, CHK_MODEL}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            in_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [7:0]            type_id;
    logic [7:0]            out_byte;
    logic [7:0]            sentence_length;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nmea_sentence_framer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .type_id         (type_id),
        .out_byte        (out_byte),
        .sentence_length (sentence_length),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // predictor copy of configuration and framing state
    logic [HDR_MAX_W-1:0] cfg_pat [NUM_PATTERNS];
    logic [31:0]          cfg_ids;
    logic [2:0]           cfg_cnt;
    logic [HDR_MAX_W-1:0] next_pat [NUM_PATTERNS];

    phase_t     fr_phase;
    logic [7:0] fr_hdr [HL];
    int         fr_fill;
    logic [7:0] fr_id;
    int         fr_count;

    frame_res_t step_res [$];
    frame_res_t due_results [$];

    int fed_items;
    int calm_left;
    int settings_cnt;
    int fault_cnt;
    int checked_cnt;
    int reject_seen;
    int trunc_seen;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit is_nmea(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_ZERO && c <= CH_NINE) ||
               c == CH_DOLLAR || c == CH_MINUS || c == CH_COMMA || c == CH_DOT ||
               c == CH_STAR;
    endfunction

    function automatic void cfg_apply(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_PATTERN_A: cfg_pat[0] = d;
            REG_PATTERN_B: cfg_pat[1] = d;
            REG_PATTERN_C: cfg_pat[2] = d;
            REG_PATTERN_D: cfg_pat[3] = d;
            REG_TYPE_IDS:  cfg_ids = d[31:0];
            REG_TYPE_CNT:  cfg_cnt = d[2:0];
            default: ;
        endcase
    endfunction

    // header complete: first enabled pattern that matches wins
    function automatic void close_header();
        int  n;
        int  k;
        int  i;
        bit  hit;
        bit  same;
        n = int'(cfg_cnt);
        if (n > NUM_TYPES_DEF)
            n = NUM_TYPES_DEF;
        if (n > NUM_PATTERNS)
            n = NUM_PATTERNS;
        hit = 1'b0;
        for (k = 0; k < n && !hit; k++)
        begin
            same = 1'b1;
            for (i = 0; i < HL; i++)
                if (fr_hdr[i] != cfg_pat[k][HDR_MAX_W-1-8*i -: 8])
                    same = 1'b0;
            if (same)
            begin
                hit      = 1'b1;
                fr_id    = cfg_ids[8*k +: 8];
                fr_phase = PH_PAYLOAD;
                fr_count = HL;
                for (i = 0; i < HL; i++)
                    step_res.push_back('{ST_BYTE, fr_id, fr_hdr[i], 8'h00, 1'b0});
            end
        end
        if (!hit)
        begin
            fr_phase = PH_HUNT;
            fr_fill  = 0;
            step_res.push_back(REJECT_RES);
        end
    endfunction

    function automatic void frame_step(input logic [7:0] c, output bit ignored);
        ignored = 1'b0;
        step_res.delete();
        case (fr_phase)
            PH_HUNT:
            begin
                if (c == CH_DOLLAR)
                begin
                    fr_hdr[0] = c;
                    fr_fill   = 1;
                    fr_phase  = PH_HEADER;
                    if (fr_fill >= HL)
                        close_header();
                end
                else
                    ignored = 1'b1;
            end
            PH_HEADER:
            begin
                if (c == CH_DOLLAR)
                begin
                    fr_hdr[0] = c;
                    fr_fill   = 1;
                end
                else if (fr_fill < HL)
                begin
                    fr_hdr[fr_fill] = c;
                    fr_fill++;
                end
                if (fr_fill >= HL)
                    close_header();
            end
            default:
            begin
                if (is_nmea(c))
                begin
                    step_res.push_back('{ST_BYTE, fr_id, c, 8'h00, 1'b0});
                    fr_count++;
                    if (fr_count + 2 >= MS)
                    begin
                        step_res.push_back('{ST_TRUNC, fr_id, CH_CR, 8'h00, 1'b0});
                        step_res.push_back('{ST_TRUNC, fr_id, CH_LF, 8'(fr_count + 2), 1'b1});
                        fr_phase = PH_HUNT;
                        fr_fill  = 0;
                    end
                end
                else
                begin
                    // terminating byte is swallowed, CR LF appended
                    step_res.push_back('{ST_TERM, fr_id, CH_CR, 8'h00, 1'b0});
                    step_res.push_back('{ST_TERM, fr_id, CH_LF, 8'(fr_count + 2), 1'b1});
                    fr_phase = PH_HUNT;
                    fr_fill  = 0;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_alpha();
        int i;
        i = $urandom_range(0, 7);
        return HDR_ALPHABET[8*i +: 8];
    endfunction

    function automatic logic [7:0] nmea_char();
        int r;
        r = $urandom_range(0, 40);
        if (r < 26)
            return CH_UPPER_A + 8'(r);
        if (r < 36)
            return CH_ZERO + 8'(r - 26);
        case (r)
            36:      return CH_DOLLAR;
            37:      return CH_MINUS;
            38:      return CH_COMMA;
            39:      return CH_DOT;
            default: return CH_STAR;
        endcase
    endfunction

    function automatic logic [7:0] end_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 4);
        case (r)
            0:       b = CH_CR;
            1:       b = CH_LF;
            2:       b = 8'h00;
            3:       b = 8'hff;
            default:
            begin
                b = 8'($urandom_range(0, 255));
                while (is_nmea(b))
                    b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    function automatic logic [HDR_MAX_W-1:0] rand_pattern();
        logic [HDR_MAX_W-1:0] p;
        int                   i;
        p = '0;
        p[HDR_MAX_W-1 -: 8] = CH_DOLLAR;
        for (i = 1; i < HL; i++)
            p[HDR_MAX_W-1-8*i -: 8] = pick_alpha();
        return p;
    endfunction

    // sender spacing: mostly back to back, some short gaps, a few long, calm stretches
    function automatic int next_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input row_chk_t chk = CHK_MODEL);
        int gap;
        bit ign;
        gap = next_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_step(b, ign);
        case (chk)
            CHK_MODEL:  foreach (step_res[i]) due_results.push_back(step_res[i]);
            CHK_REJECT: due_results.push_back(REJECT_RES);
            default: ;
        endcase
        if (!ign)
            fed_items++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_apply(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random junk above the register width must not leak in
    task automatic load_types(input logic [31:0] ids, input logic [2:0] cnt);
        logic [CFG_DATA_W-1:0] rnd;
        rnd = CFG_DATA_W'({$urandom(), $urandom()});
        cfg_write(REG_PATTERN_A, next_pat[0]);
        cfg_write(REG_PATTERN_B, next_pat[1]);
        cfg_write(REG_PATTERN_C, next_pat[2]);
        cfg_write(REG_PATTERN_D, next_pat[3]);
        cfg_write(REG_TYPE_IDS, {rnd[CFG_DATA_W-1:32], ids});
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_SPARE_6, CFG_DATA_W'({$urandom(), $urandom()}));
        else
            cfg_write(REG_SPARE_7, CFG_DATA_W'({$urandom(), $urandom()}));
        cfg_write(REG_TYPE_CNT, {rnd[CFG_DATA_W-1:3], cnt});
        settings_cnt++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one sentence attempt: noise, broken header with restart, or a well-formed frame
    task automatic send_sentence(input bit force_trunc);
        int kind;
        int k;
        int n;
        int i;
        bit copy;
        kind = force_trunc ? 9 : $urandom_range(0, 9);
        if (kind == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
            return;
        end
        push_byte(CH_DOLLAR);
        if (kind == 1)
        begin
            n = $urandom_range(1, HL - 2);
            repeat (n) push_byte(pick_alpha());
            push_byte(CH_DOLLAR);
        end
        k    = force_trunc ? 0 : $urandom_range(0, NUM_PATTERNS - 1);
        copy = force_trunc || ($urandom_range(0, 4) < 3);
        for (i = 1; i < HL; i++)
            push_byte(copy ? cfg_pat[k][HDR_MAX_W-1-8*i -: 8] : pick_alpha());
        if (force_trunc)
            n = MS - 2 - HL;
        else if ($urandom_range(0, 39) == 0)
            n = $urandom_range(MS - HL - 18, MS - HL - 6);
        else
            n = $urandom_range(0, 12);
        repeat (n) push_byte(nmea_char());
        if (!force_trunc)
            push_byte(end_char());
    endtask

    // result side: random stall, one long hold-off to back the block up
    initial
    begin : rx_pacing
        int n;
        int r;
        bit v;
        bit hold_done;
        out_stall = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && fed_items >= HOLD_AT)
            begin
                hold_done = 1'b1;
                v = 1'b1;
                n = LONG_HOLD;
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                begin
                    v = 1'b0;
                    n = $urandom_range(1, 12);
                end
                else if (r < 17)
                begin
                    v = 1'b1;
                    n = $urandom_range(1, 3);
                end
                else if (r < 19)
                begin
                    v = 1'b1;
                    n = $urandom_range(6, 25);
                end
                else
                begin
                    v = 1'b0;
                    n = $urandom_range(30, 60);
                end
            end
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= v;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                if (fault_cnt < MAX_REPORTS)
                    $display("%0t: unexpected result st=%0d id=%02h byte=%02h len=%0d last=%0d",
                             $realtime, status, type_id, out_byte, sentence_length, last);
                fault_cnt++;
            end
            else
            begin
                e = due_results.pop_front();
                checked_cnt++;
                if (e.st == ST_REJECT)
                    reject_seen++;
                if (e.st == ST_TRUNC && e.last)
                    trunc_seen++;
                if (status !== e.st || type_id !== e.id || out_byte !== e.data ||
                    sentence_length !== e.len || last !== e.last)
                begin
                    if (fault_cnt < MAX_REPORTS)
                    begin
                        $display("%0t: beat %0d expected st=%0d id=%02h byte=%02h len=%0d last=%0d",
                                 $realtime, checked_cnt, e.st, e.id, e.data, e.len, e.last);
                        $display("    got st=%0d id=%02h byte=%02h len=%0d last=%0d",
                                 status, type_id, out_byte, sentence_length, last);
                    end
                    fault_cnt++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int p;
        int r;
        int k;
        int base;
        int tgt;
        int n_sent;
        bit first;
        logic [31:0] ids;
        logic [2:0]  cnt;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        for (k = 0; k < NUM_PATTERNS; k++)
            cfg_pat[k] = '0;
        cfg_ids  = '0;
        cfg_cnt  = '0;
        fr_phase = PH_HUNT;
        for (k = 0; k < HL; k++)
            fr_hdr[k] = '0;
        fr_fill      = 0;
        fr_id        = '0;
        fr_count     = 0;
        fed_items    = 0;
        calm_left    = 0;
        settings_cnt = 0;
        fault_cnt    = 0;
        checked_cnt  = 0;
        reject_seen  = 0;
        trunc_seen   = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset config rejects everything, then a known type set
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (r == PRE_ROWS)
            begin
                wait_quiet();
                next_pat[0] = "$GPGGA";
                next_pat[1] = "$GPRMC";
                next_pat[2] = "$GNGSA";
                next_pat[3] = '1;
                cfg_write(REG_SPARE_6, '1);
                cfg_write(REG_SPARE_7, '1);
                load_types(32'hff80_0100, 3'd4);
            end
            push_byte(DIR_TABLE[r].b, DIR_TABLE[r].chk);
        end

        base = fed_items;
        for (p = 0; p < RAND_PHASES; p++)
        begin
            wait_quiet();
            for (k = 0; k < NUM_PATTERNS; k++)
                next_pat[k] = (k > 0 && $urandom_range(0, 4) == 0) ? next_pat[k-1]
                                                                   : rand_pattern();
            ids = $urandom();
            case (p)
                0:       cnt = 3'($urandom_range(1, 4));
                1:       cnt = 3'd0;
                2:
                begin
                    cnt = 3'd7;
                    ids = '1;
                end
                3:
                begin
                    cnt = 3'd5;
                    ids = '0;
                end
                4:
                begin
                    cnt = 3'd6;
                    next_pat[2] = '0;
                    next_pat[3] = '1;
                end
                default: cnt = 3'($urandom_range(1, 7));
            endcase
            load_types(ids, cnt);
            tgt    = base + (p + 1) * (RAND_ITEMS / RAND_PHASES);
            first  = (p == 0);
            n_sent = 0;
            // every setting sees at least one sentence even after a long one before it
            while (fed_items < tgt || n_sent == 0)
            begin
                send_sentence(first);
                first = 1'b0;
                n_sent++;
                if (p == 3 && n_sent == 3)
                    wait_quiet();
            end
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0d expected results never arrived", due_results.size());
            fault_cnt += due_results.size();
        end

        $display("Framed %0d live input beats across %0d type settings.", fed_items, settings_cnt);
        $display("Checked %0d result beats: %0d header rejections, %0d truncated sentences.",
                 checked_cnt, reject_seen, trunc_seen);
        if (fault_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* nmea_sentence_framer.f */
hw/rtl/nsf_pkg.sv
hw/rtl/nsf_front.sv
hw/rtl/nsf_cmd_fifo.sv
hw/rtl/nsf_back.sv
hw/rtl/nmea_sentence_framer.sv
verif/tb.sv
